>>> sv/spq_pkg.sv
// ============================================================================
// spq_pkg: shared types and codes of the sorted priority queue
// Request and response words, the command word handed to every cell, and the
// request and status codes.
// ============================================================================
package spq_pkg;

  // Request codes.
  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_DEQUEUE = 2'd1;
  localparam logic [1:0] REQ_REMOVE  = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  // Input word.
  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] item_tag;
    logic [7:0]  item_priority;
  } req_t;

  // Output word.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_tag;
    logic [7:0]  out_priority;
    logic [4:0]  occupancy;
  } rsp_t;

  // One stored entry.
  typedef struct packed {
    logic [31:0] tag;
    logic [7:0]  prio;
  } slot_t;

  // Command broadcast to all cells in the cycle a word is accepted.
  typedef struct packed {
    logic        enq;
    logic        rem;
    logic [31:0] tag;
    logic [7:0]  prio;
  } cell_cmd_t;

endpackage

>>> sv/sorted_priority_queue_unit.sv
// ============================================================================
// sorted_priority_queue_unit: sorted priority queue on a chain of cells
// Entries sit in a row of cells, highest priority at the head (cell 0).
// Inserts and removes shift the row by one cell; a dequeue
// reads the tail cell and drops the count.
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+-------
//   in      | input     | in_valid_i / in_stall_o   | req_t
//   out     | output    | out_valid_o / out_stall_i | rsp_t
//
// The cells update at the accepting edge and the response is registered
// there, so a new word is taken in every cycle while the input is not stalled.
// The path that sets the cycle is the tag compare in each cell followed by
// the hit chain that runs from the head to the tail cell.
// Reset clears the count and the valid flag; response word and cells are left.
// The input stalls only while a response waits and the output is stalled.
// ============================================================================
module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_rsp_o
);

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int IdxW = $clog2(QUEUE_DEPTH);

  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;
  rsp_t            out_rsp_q, out_rsp_d;

  logic            accept;
  logic            full;
  logic            found;
  logic [CntW-1:0] tail_cnt;
  logic [IdxW-1:0] tail_idx;
  cell_cmd_t       cmd;

  slot_t slot   [QUEUE_DEPTH];
  logic  after  [QUEUE_DEPTH];
  logic  hit    [QUEUE_DEPTH];

  // Handshake.
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  assign full     = (count_q == CntW'(QUEUE_DEPTH));
  assign tail_cnt = count_q - CntW'(1);
  assign tail_idx = tail_cnt[IdxW-1:0];
  assign found    = hit[QUEUE_DEPTH-1];

  // Command to the cells.
  always_comb begin
    cmd.enq  = accept && (in_req_i.req_type == REQ_ENQUEUE) && !full;
    cmd.rem  = accept && (in_req_i.req_type == REQ_REMOVE);
    cmd.tag  = in_req_i.item_tag;
    cmd.prio = in_req_i.item_priority;
  end

  // Cell chain. Cell 0 sees a virtual head that always ranks higher.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    slot_t left;
    slot_t right;
    logic  left_after;
    logic  hit_in;

    if (i == 0) begin : g_head
      assign left       = '0;
      assign left_after = 1'b1;
      assign hit_in     = 1'b0;
    end else begin : g_body
      assign left       = slot[i-1];
      assign left_after = after[i-1];
      assign hit_in     = hit[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right = slot[i];
    end else begin : g_mid
      assign right = slot[i+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .in_use_i     (CntW'(i) < count_q),
      .left_i       (left),
      .left_after_i (left_after),
      .right_i      (right),
      .hit_i        (hit_in),
      .slot_o       (slot[i]),
      .after_o      (after[i]),
      .hit_o        (hit[i])
    );
  end

  // Count update and response word.
  always_comb begin
    count_d               = count_q;
    out_rsp_d.status      = ST_OK;
    out_rsp_d.out_tag     = '0;
    out_rsp_d.out_priority = '0;
    unique case (in_req_i.req_type)
      REQ_ENQUEUE: begin
        if (full) begin
          out_rsp_d.status = ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      REQ_DEQUEUE: begin
        if (count_q == '0) begin
          out_rsp_d.status = ST_EMPTY;
        end else begin
          out_rsp_d.out_tag      = slot[tail_idx].tag;
          out_rsp_d.out_priority = slot[tail_idx].prio;
          count_d                = tail_cnt;
        end
      end
      REQ_REMOVE: begin
        if (found) begin
          count_d = tail_cnt;
        end else begin
          out_rsp_d.status = ST_NOT_FOUND;
        end
      end
      default: begin
        // Unused request code leaves the queue as it is.
      end
    endcase
    out_rsp_d.occupancy = 5'(count_d);
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  // Response payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_rsp_q <= out_rsp_d;
    end
  end

endmodule

>>> sv/spq_cell.sv
// ============================================================================
// spq_cell: one slot of the sorted priority queue
// Holds one entry. On an insert it keeps its entry, takes the new one or
// takes its left neighbor's; on a remove it takes its right neighbor's once
// the matching entry lies at or ahead of it.
// ============================================================================
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk_i,
  input  cell_cmd_t cmd_i,
  input  logic      in_use_i,
  input  slot_t     left_i,
  input  logic      left_after_i,
  input  slot_t     right_i,
  input  logic      hit_i,
  output slot_t     slot_o,
  output logic      after_o,
  output logic      hit_o
);

  slot_t slot_q;
  slot_t slot_d;
  logic  match;

  // The new entry goes behind this one only if this one is strictly higher.
  assign after_o = in_use_i && (slot_q.prio > cmd_i.prio);
  assign match   = in_use_i && (slot_q.tag == cmd_i.tag);
  assign hit_o   = hit_i || match;
  assign slot_o  = slot_q;

  // Next entry of this slot.
  always_comb begin
    slot_d = slot_q;
    if (cmd_i.enq && !after_o) begin
      if (left_after_i) begin
        slot_d.tag  = cmd_i.tag;
        slot_d.prio = cmd_i.prio;
      end else begin
        slot_d = left_i;
      end
    end else if (cmd_i.rem && hit_o) begin
      slot_d = right_i;
    end
  end

  // Entry storage needs no reset: slots past the count are never read.
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

endmodule

>>> sv/spq_checker.sv
// ============================================================================
// spq_checker: port-level checks of the sorted priority queue
// Watches the ports of the top level only and is bound to it.
// ============================================================================
module spq_checker
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16
) (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input rsp_t out_rsp_o
);

  localparam logic [4:0] FullOcc = 5'(QUEUE_DEPTH);

  // A stalled response word holds.
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled response word changed");

  // Every accepted request gives a response in the next cycle.
  a_rsp_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request gave no response word");

  // A failed request carries no entry.
  a_zero_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status != ST_OK
      |-> out_rsp_o.out_tag == '0 && out_rsp_o.out_priority == '0)
    else $error("failed request carried entry fields");

  // An empty report shows no entries, a full report shows all of them.
  a_occupancy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == ST_EMPTY || out_rsp_o.status == ST_FULL)
      |-> (out_rsp_o.status == ST_EMPTY && out_rsp_o.occupancy == '0) ||
          (out_rsp_o.status == ST_FULL && out_rsp_o.occupancy == FullOcc))
    else $error("occupancy disagrees with empty or full status");

endmodule

bind sorted_priority_queue_unit spq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_spq_checker (.*);

>>> tb/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// sorted_priority_queue_unit_tb: self-checking bench for the sorted queue
// Drives enqueue, dequeue and remove words through the valid/stall input and
// checks each response word against a shadow copy of the sorted entry list
// or a typed row's expected word. A short directed table covers the corner
// cases. Random traffic follows in fill, drain and mixed phases, with random
// idling on both sides and long output hold-offs that back the block up.
// ============================================================================
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int DEPTH          = 16;
  localparam int RANDOM_ITEMS   = 830;
  localparam int PHASE_LEN      = 40;
  localparam int CALM_ITEMS     = 100;
  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4;

  // The unused request code is ignored by the block but still answered.
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Traffic mixes of the random part.
  localparam int MODE_FILL  = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIX   = 2;

  // One row of the directed table. Rows with reps above one step the tag.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] tag;
    logic [7:0]  prio;
    logic [4:0]  reps;
    logic        rnd_prio;
    logic        typed;
    rsp_t        want;
  } step_t;

  localparam int PLAN_ROWS = 16;
  localparam step_t PLAN [PLAN_ROWS] = '{
    // Dequeue and remove on an empty queue, then the ignored code.
    '{REQ_DEQUEUE, 32'h0000_0000, 8'h00, 5'd1, 1'b0, 1'b1, '{ST_EMPTY, 32'h0, 8'h00, 5'd0}},
    '{REQ_REMOVE,  32'hDEAD_BEEF, 8'h00, 5'd1, 1'b0, 1'b1, '{ST_NOT_FOUND, 32'h0, 8'h00, 5'd0}},
    '{REQ_UNUSED,  32'hFFFF_FFFF, 8'hFF, 5'd1, 1'b0, 1'b1, '{ST_OK, 32'h0, 8'h00, 5'd0}},
    // Field extremes, then ties at the lowest and highest priority.
    '{REQ_ENQUEUE, 32'hFFFF_FFFF, 8'hFF, 5'd1, 1'b0, 1'b1, '{ST_OK, 32'h0, 8'h00, 5'd1}},
    '{REQ_ENQUEUE, 32'h0000_0000, 8'h00, 5'd1, 1'b0, 1'b1, '{ST_OK, 32'h0, 8'h00, 5'd2}},
    '{REQ_ENQUEUE, 32'h0000_0005, 8'h00, 5'd1, 1'b0, 1'b0, '0},
    '{REQ_ENQUEUE, 32'h0000_0007, 8'hFF, 5'd1, 1'b0, 1'b0, '0},
    // The tail goes first: lowest priority, oldest among equals.
    '{REQ_DEQUEUE, 32'h0000_0000, 8'h00, 5'd1, 1'b0, 1'b0, '0},
    '{REQ_REMOVE,  32'hFFFF_FFFF, 8'h00, 5'd1, 1'b0, 1'b0, '0},
    '{REQ_REMOVE,  32'h0000_1234, 8'h00, 5'd1, 1'b0, 1'b1, '{ST_NOT_FOUND, 32'h0, 8'h00, 5'd2}},
    // Fill to capacity, then one enqueue too many.
    '{REQ_ENQUEUE, 32'h0000_0100, 8'h00, 5'd14, 1'b1, 1'b0, '0},
    '{REQ_ENQUEUE, 32'hAAAA_5555, 8'h80, 5'd1, 1'b0, 1'b1, '{ST_FULL, 32'h0, 8'h00, 5'd16}},
    // Remove from the middle of a full queue, then take the tail.
    '{REQ_REMOVE,  32'h0000_0105, 8'h00, 5'd1, 1'b0, 1'b0, '0},
    '{REQ_DEQUEUE, 32'h0000_0000, 8'h00, 5'd1, 1'b0, 1'b0, '0},
    // A duplicate tag: the remove hits the copy nearest the head.
    '{REQ_ENQUEUE, 32'h0000_0007, 8'h00, 5'd1, 1'b0, 1'b0, '0},
    '{REQ_REMOVE,  32'h0000_0007, 8'h00, 5'd1, 1'b0, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni    = 1'b0;
  logic in_valid  = 1'b0;
  req_t in_req    = '0;
  logic out_stall = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  // Shadow copy of the sorted entry list, head at index zero.
  slot_t shadow_entries [DEPTH];
  int    shadow_count = 0;

  rsp_t awaited_rsp [$];
  int   error_count  = 0;
  int   words_sent   = 0;
  int   words_seen   = 0;
  int   status_seen [4] = '{0, 0, 0, 0};
  int   quiet_cycles = 0;
  bit   idle_on      = 1'b1;
  bit   hold_out     = 1'b0;

  sorted_priority_queue_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp_o)
  );

  // Clock: 20 ns period.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one request to the shadow list and returns the response it earns.
  function automatic rsp_t queue_response(input req_t w);
    rsp_t r;
    int   pos;
    int   i;
    r = '0;
    r.status = ST_OK;
    case (w.req_type)
      REQ_ENQUEUE: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_entries[pos].prio > w.item_priority) pos++;
          for (i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos] = '{tag: w.item_tag, prio: w.item_priority};
          shadow_count++;
        end
      end
      REQ_DEQUEUE: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_tag      = shadow_entries[shadow_count - 1].tag;
          r.out_priority = shadow_entries[shadow_count - 1].prio;
          shadow_count--;
        end
      end
      REQ_REMOVE: begin
        pos = 0;
        while (pos < shadow_count && shadow_entries[pos].tag != w.item_tag) pos++;
        if (pos >= shadow_count) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i + 1];
          shadow_count--;
        end
      end
      default: begin
      end
    endcase
    r.occupancy = 5'(shadow_count);
    return r;
  endfunction

  // Random request; half of the tags, when the list is not empty, name a held entry.
  function automatic req_t random_request(input int mode);
    req_t w;
    int   roll;
    int   enq_pct;
    int   deq_pct;
    roll = $urandom_range(0, 99);
    case (mode)
      MODE_FILL:  begin enq_pct = 70; deq_pct = 12; end
      MODE_DRAIN: begin enq_pct = 20; deq_pct = 60; end
      default:    begin enq_pct = 40; deq_pct = 30; end
    endcase
    if (roll < enq_pct) begin
      w.req_type = REQ_ENQUEUE;
    end else if (roll < enq_pct + deq_pct) begin
      w.req_type = REQ_DEQUEUE;
    end else if (roll < 97) begin
      w.req_type = REQ_REMOVE;
    end else begin
      w.req_type = REQ_UNUSED;
    end
    // A small tag pool makes duplicates; full-width tags exercise every bit.
    roll = $urandom_range(0, 3);
    if (roll == 0) begin
      w.item_tag = $urandom();
    end else if (roll == 1 || shadow_count == 0) begin
      w.item_tag = $urandom_range(0, 31);
    end else begin
      w.item_tag = shadow_entries[$urandom_range(0, shadow_count - 1)].tag;
    end
    // Narrow priorities make ties common.
    if ($urandom_range(0, 1) == 0) begin
      w.item_priority = 8'($urandom_range(0, 7));
    end else begin
      w.item_priority = 8'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // Offers one word, waits for it to be taken and records what must come back.
  task automatic offer_word(input req_t w, input bit typed, input rsp_t want);
    rsp_t predicted;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = queue_response(w);
    awaited_rsp.push_back(typed ? want : predicted);
    words_sent++;
  endtask

  // Output side: random stall bursts, and long hold-offs on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_out) begin
        hold_out = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        out_stall <= 0;
      end
    end
  end

  // Response checker: every word taken is compared with the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall) begin
      words_seen++;
      if (awaited_rsp.size() == 0) begin
        $display("%0t: response word with nothing expected: %p", $time, out_rsp_o);
        error_count++;
      end else begin
        want = awaited_rsp.pop_front();
        status_seen[want.status]++;
        if (out_rsp_o.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_rsp_o.status);
          error_count++;
        end
        if (out_rsp_o.out_tag !== want.out_tag) begin
          $display("%0t: out_tag expected %h got %h", $time, want.out_tag, out_rsp_o.out_tag);
          error_count++;
        end
        if (out_rsp_o.out_priority !== want.out_priority) begin
          $display("%0t: out_priority expected %0d got %0d", $time, want.out_priority,
                   out_rsp_o.out_priority);
          error_count++;
        end
        if (out_rsp_o.occupancy !== want.occupancy) begin
          $display("%0t: occupancy expected %0d got %0d", $time, want.occupancy,
                   out_rsp_o.occupancy);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any word moving ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin
    step_t row;
    req_t  w;
    int    s;
    int    k;
    int    n;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table.
    for (s = 0; s < PLAN_ROWS; s++) begin
      row = PLAN[s];
      for (k = 0; k < row.reps; k++) begin
        w.req_type      = row.op;
        w.item_tag      = row.tag + 32'(k);
        w.item_priority = row.rnd_prio ? 8'($urandom_range(0, 255)) : row.prio;
        offer_word(w, row.typed, row.want);
      end
    end

    // Random phases cycle through fill, drain and mixed traffic.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        idle_on = (n < RANDOM_ITEMS - CALM_ITEMS) && ($urandom_range(0, 3) != 0);
      end
      if (n == 200 || n == 520) begin
        hold_out = 1'b1;
      end
      offer_word(random_request((n / PHASE_LEN) % 3), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Wait for the last responses, then watch for stray words.
    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d requests and %0d responses on a %0d-entry queue.",
             words_sent, words_seen, DEPTH);
    $display("Responses by status: ok %0d, empty %0d, not found %0d, full %0d.",
             status_seen[ST_OK], status_seen[ST_EMPTY], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL]);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
